@@ hdl/i2cm_pkg.sv @@
`timescale 1ns / 1ps

package i2cm_pkg;

  // Request modes
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;
  localparam logic [2:0] MODE_ACK   = 3'd5;
  localparam logic [2:0] MODE_NACK  = 3'd6;
  localparam logic [2:0] MODE_RSVD  = 3'd7;

  // Segment (phase) codes; idle is zero
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SEG1 = 3'd1;
  localparam logic [2:0] PH_SEG2 = 3'd2;
  localparam logic [2:0] PH_SEG3 = 3'd3;
  localparam logic [2:0] PH_SEG4 = 3'd4;
  localparam logic [2:0] PH_SEG5 = 3'd5;
  localparam logic [2:0] PH_SEG6 = 3'd6;

  localparam logic [2:0]  BIT_LAST      = 3'd7;
  localparam logic [15:0] HALF_PER_INIT = 16'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_level;
  } i2cm_req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       cmd_rejected;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
  } i2cm_res_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  kind;
    logic [2:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [16:0] tick_timer;
    logic        scl;
    logic        sda;
    logic        sda_dir;
    logic        ack;
  } i2cm_state_t;

  localparam i2cm_state_t STATE_RESET = '{
    phase:      PH_IDLE,
    kind:       MODE_TICK,
    bit_count:  3'd0,
    shift_reg:  8'd0,
    tick_timer: 17'd0,
    scl:        1'b1,
    sda:        1'b1,
    sda_dir:    1'b1,
    ack:        1'b1
  };

endpackage

@@ hdl/i2cm_step.sv @@
`timescale 1ns / 1ps

module i2cm_step import i2cm_pkg::*; (
  input  i2cm_state_t state,
  input  i2cm_req_t   req,
  input  logic [15:0] half_period_ticks,
  output i2cm_state_t state_next,
  output i2cm_res_t   res
);

  // Enter a segment: set phase, pin levels and hold time for the current command
  function automatic i2cm_state_t enter_seg(input i2cm_state_t s, input logic [2:0] seg,
                                            input logic [15:0] h);
    i2cm_state_t r;
    logic        dbl;
    r   = s;
    dbl = 1'b0;
    r.phase = seg;
    unique case (s.kind)
      MODE_START: begin
        if (seg == PH_SEG1) begin
          r.scl = 1'b1;
          r.sda = 1'b0;
        end else begin
          r.scl = 1'b0;
        end
        dbl = 1'b1;
      end
      MODE_STOP: begin
        if (seg == PH_SEG1) begin
          r.sda = 1'b0;
          r.scl = 1'b1;
        end else begin
          r.sda = 1'b1;
        end
        dbl = 1'b1;
      end
      MODE_ACK: begin
        if (seg == PH_SEG1) r.sda = 1'b0;
        else if (seg == PH_SEG2) r.scl = 1'b0;
        else r.scl = 1'b1;
      end
      MODE_NACK: begin
        if (seg == PH_SEG1) begin
          r.sda = 1'b1;
          r.scl = 1'b0;
        end else begin
          r.scl = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (seg == PH_SEG1) begin
          r.sda = s.shift_reg[7];
          r.scl = 1'b0;
        end else if (seg == PH_SEG4) begin
          r.sda_dir = 1'b0;
          r.scl     = 1'b0;
        end else if (seg == PH_SEG2 || seg == PH_SEG5) begin
          r.scl = 1'b1;
        end else begin
          r.scl = 1'b0;
        end
      end
      default: begin
        // read byte: SCL high only in the sampling segment
        r.scl = (seg == PH_SEG2);
      end
    endcase
    r.tick_timer = dbl ? {h, 1'b0} : {1'b0, h};
    return r;
  endfunction

  i2cm_state_t s;
  logic        rejected;
  logic        done;
  logic        finish;

  always_comb begin
    s        = state;
    rejected = 1'b0;
    done     = 1'b0;
    finish   = 1'b0;

    if (req.mode == MODE_TICK) begin
      if (state.phase != PH_IDLE) begin
        if (state.tick_timer <= 17'd1) begin
          // segment over: pick the next segment or complete the command
          unique case (state.kind)
            MODE_START, MODE_STOP: begin
              if (state.phase == PH_SEG1) s = enter_seg(state, PH_SEG2, half_period_ticks);
              else finish = 1'b1;
            end
            MODE_ACK: begin
              if (state.phase == PH_SEG1 || state.phase == PH_SEG2) begin
                s = enter_seg(state, state.phase + 3'd1, half_period_ticks);
              end else begin
                s.scl  = 1'b0;
                finish = 1'b1;
              end
            end
            MODE_NACK: begin
              if (state.phase == PH_SEG1) begin
                s = enter_seg(state, PH_SEG2, half_period_ticks);
              end else begin
                s.scl  = 1'b0;
                finish = 1'b1;
              end
            end
            MODE_WRITE: begin
              if (state.phase == PH_SEG1 || state.phase == PH_SEG2 ||
                  state.phase == PH_SEG4) begin
                s = enter_seg(state, state.phase + 3'd1, half_period_ticks);
              end else if (state.phase == PH_SEG3) begin
                if (state.bit_count < BIT_LAST) begin
                  s.bit_count = state.bit_count + 3'd1;
                  s.shift_reg = {state.shift_reg[6:0], 1'b0};
                  s = enter_seg(s, PH_SEG1, half_period_ticks);
                end else begin
                  s = enter_seg(state, PH_SEG4, half_period_ticks);
                end
              end else if (state.phase == PH_SEG5) begin
                s.ack = req.sda_level;
                s = enter_seg(s, PH_SEG6, half_period_ticks);
              end else begin
                s.sda_dir = 1'b1;
                finish    = 1'b1;
              end
            end
            MODE_READ: begin
              if (state.phase == PH_SEG1) begin
                s = enter_seg(state, PH_SEG2, half_period_ticks);
              end else if (state.phase == PH_SEG2) begin
                s.shift_reg = {state.shift_reg[6:0], req.sda_level};
                s = enter_seg(s, PH_SEG3, half_period_ticks);
              end else if (state.phase == PH_SEG3 && state.bit_count < BIT_LAST) begin
                s.bit_count = state.bit_count + 3'd1;
                s = enter_seg(s, PH_SEG1, half_period_ticks);
              end else begin
                s.sda_dir = 1'b1;
                finish    = 1'b1;
              end
            end
            default: finish = 1'b1;
          endcase
        end else begin
          s.tick_timer = state.tick_timer - 17'd1;
        end
      end
    end else if (req.mode != MODE_RSVD) begin
      // command: taken only when idle
      if (state.phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        s.kind      = req.mode;
        s.bit_count = 3'd0;
        if (req.mode == MODE_WRITE) s.shift_reg = req.tx_byte;
        if (req.mode == MODE_READ) begin
          s.shift_reg = 8'd0;
          s.sda_dir   = 1'b0;
        end
        s = enter_seg(s, PH_SEG1, half_period_ticks);
      end
    end

    if (finish) begin
      s.phase      = PH_IDLE;
      s.tick_timer = 17'd0;
      done         = 1'b1;
    end
  end

  assign state_next = s;

  // Result fields from the updated state
  assign res.scl_level    = s.scl;
  assign res.sda_out      = s.sda;
  assign res.sda_drive    = s.sda_dir;
  assign res.busy_res     = (s.phase != PH_IDLE);
  assign res.cmd_rejected = rejected;
  assign res.done_res     = done;
  assign res.rx_byte      = (done && state.kind == MODE_READ) ? s.shift_reg : 8'd0;
  assign res.ack_bit      = s.ack;

endmodule

@@ hdl/i2c_master_bit_engine.sv @@
`timescale 1ns / 1ps
// I2C master bit engine.
// Request channel (req_valid/req_ready/req): each request is a tick that
// carries the sampled SDA level, or a command (start, stop, write byte, read
// byte, ACK, NACK). A command is taken only while idle; one arriving while
// busy is dropped and flagged as rejected. Ticks pace SCL/SDA segments.
// Result channel (res_valid/res_ready/res): exactly one result per request,
// giving pin levels, busy/done/rejected flags, received byte and ack bit.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle while req_ready is high; the state update
// and result for a request come from one combinational step.
// A stalled result register holds; req_ready drops only while a result is
// waiting and res_ready is low, and rises again in the cycle it is taken.
// Config: cfg_we/cfg_data write half_period_ticks (reset 5); write it only
// while idle. Reset (rst, synchronous) returns to idle with SCL and SDA high
// and driven, and empties the result register.
module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  i2cm_req_t   req,
  output logic        res_valid,
  input  logic        res_ready,
  output i2cm_res_t   res,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  i2cm_state_t state;
  i2cm_state_t state_next;
  i2cm_res_t   step_res;
  logic [15:0] half_period_ticks;
  logic        accept;

  assign req_ready = !res_valid || res_ready;
  assign accept    = req_valid && req_ready;

  i2cm_step u_step (
    .state             (state),
    .req               (req),
    .half_period_ticks (half_period_ticks),
    .state_next        (state_next),
    .res               (step_res)
  );

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PER_INIT;
    end else if (cfg_we) begin
      half_period_ticks <= cfg_data;
    end
  end

  // Bus state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= step_res;
    end
  end

  // A waiting result reports busy consistent with the state it left
  a_busy_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.busy_res == (state.phase != PH_IDLE)))
    else $error("busy flag disagrees with bus state");

  // Completion and rejection are exclusive
  a_done_rej: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.done_res && res.cmd_rejected))
    else $error("done and rejected both set");

  // A command taken while busy leaves the state untouched
  a_rej_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && state.phase != PH_IDLE && req.mode != MODE_TICK && req.mode != MODE_RSVD)
      |=> (state == $past(state)))
    else $error("rejected command changed state");

  // Received byte is zero unless a command completes
  a_rx_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.done_res) |-> (res.rx_byte == 8'd0))
    else $error("rx_byte set without done");

endmodule
